FILE: rtl/deq_pkg.sv
package deq_pkg;

	// Queue capacity and derived widths.
	localparam int DEPTH   = 64;
	localparam int ADDR_W  = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int DATA_W  = 32;
	localparam int CMD_W   = 2;
	localparam int STAT_W  = 2;
	// Position sums of head and count are held one bit wider than the count.
	localparam int POS_W   = CNT_W + 1;

	// Result payload: front, back, count, empty flag, padded to whole bytes.
	localparam int OUT_RAW_W = 2 * DATA_W + CNT_W + 1;
	localparam int OUT_W     = ((OUT_RAW_W + 7) / 8) * 8;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH_BACK  = 2'd0,
		CMD_PUSH_FRONT = 2'd1,
		CMD_POP_BACK   = 2'd2,
		CMD_POP_FRONT  = 2'd3
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_UNDER = 2'd1,
		ST_OVER  = 2'd2,
		ST_RSVD  = 2'd3
	} status_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic latch_in;  // capture the accepted transfer
		logic exec;      // apply the operation and write the RAM
		logic load_out;  // load the result register
	} dp_cmd_t;

endpackage

FILE: rtl/deq_ram.sv
module deq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

FILE: rtl/deq_ctrl.sv
module deq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output deq_pkg::dp_cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_EXEC = 4'b0010,
		S_READ = 4'b0100,
		S_LOAD = 4'b1000
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   load_ok;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	// The result register may be refilled once it is empty or being drained.
	assign load_ok   = (state_q == S_LOAD) && (!out_valid_q || out_ready);

	always_comb begin
		cmd          = '0;
		cmd.latch_in = in_valid && (state_q == S_IDLE);
		cmd.exec     = (state_q == S_EXEC);
		cmd.load_out = load_ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_EXEC;
				end
				S_EXEC: state_q <= S_READ;
				S_READ: state_q <= S_LOAD;
				S_LOAD: begin
					if (load_ok) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase

			if (load_ok) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.latch_in |=> state_q == S_EXEC)
		else $error("accepted transfer did not start execution");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> out_valid_q && state_q == S_IDLE)
		else $error("result load did not raise output valid");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready && !load_ok) |=> out_valid_q)
		else $error("stalled result was dropped");

endmodule

FILE: rtl/deq_dp.sv
module deq_dp (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  deq_pkg::dp_cmd_t                      cmd,
	input  logic [deq_pkg::CMD_W-1:0]             in_cmd,
	input  logic [deq_pkg::DATA_W-1:0]            in_value,
	output logic [deq_pkg::DATA_W-1:0]            front_value,
	output logic [deq_pkg::DATA_W-1:0]            back_value,
	output logic [deq_pkg::CNT_W-1:0]             entry_count,
	output logic                                  is_empty,
	output logic [deq_pkg::STAT_W-1:0]            status
);

	deq_pkg::cmd_t                    cmd_q;
	logic [deq_pkg::DATA_W-1:0]       value_q;
	logic [deq_pkg::ADDR_W-1:0]       head_q;
	logic [deq_pkg::CNT_W-1:0]        occ_q;
	deq_pkg::status_t                 status_q;

	logic [deq_pkg::DATA_W-1:0]       front_q, back_q;
	logic [deq_pkg::CNT_W-1:0]        count_q;
	logic                             empty_q;
	deq_pkg::status_t                 out_status_q;

	logic                             is_push, full, empty;
	logic [deq_pkg::ADDR_W-1:0]       head_dec, tail_pos, back_pos;
	logic                             ram_we;
	logic [deq_pkg::ADDR_W-1:0]       ram_waddr;
	logic [deq_pkg::DATA_W-1:0]       rdata_a, rdata_b;

	// Reduce a position below twice the depth into the ring.
	function automatic logic [deq_pkg::ADDR_W-1:0] wrap_pos(
			input logic [deq_pkg::POS_W-1:0] p);
		logic [deq_pkg::POS_W-1:0] r;
		r = (p >= deq_pkg::POS_W'(deq_pkg::DEPTH)) ? p - deq_pkg::POS_W'(deq_pkg::DEPTH) : p;
		return r[deq_pkg::ADDR_W-1:0];
	endfunction

	assign is_push  = (cmd_q == deq_pkg::CMD_PUSH_BACK) || (cmd_q == deq_pkg::CMD_PUSH_FRONT);
	assign full     = (occ_q == deq_pkg::CNT_W'(deq_pkg::DEPTH));
	assign empty    = (occ_q == '0);
	assign head_dec = (head_q == '0) ? deq_pkg::ADDR_W'(deq_pkg::DEPTH - 1) : head_q - 1'b1;
	assign tail_pos = wrap_pos(deq_pkg::POS_W'(head_q) + deq_pkg::POS_W'(occ_q));
	// Back entry sits one below the tail; only meaningful when not empty.
	assign back_pos = wrap_pos(deq_pkg::POS_W'(head_q) + deq_pkg::POS_W'(occ_q)
		- deq_pkg::POS_W'(1));

	assign ram_we    = cmd.exec && is_push && !full;
	assign ram_waddr = (cmd_q == deq_pkg::CMD_PUSH_FRONT) ? head_dec : tail_pos;

	deq_ram #(
		.WIDTH(deq_pkg::DATA_W),
		.DEPTH(deq_pkg::DEPTH)
	) u_ram (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ram_waddr),
		.wdata   (value_q),
		.raddr_a (head_q),
		.raddr_b (back_pos),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			occ_q  <= '0;
		end else if (cmd.exec) begin
			if (is_push) begin
				if (!full) begin
					occ_q <= occ_q + 1'b1;
					if (cmd_q == deq_pkg::CMD_PUSH_FRONT) head_q <= head_dec;
				end
			end else if (!empty) begin
				occ_q <= occ_q - 1'b1;
				if (cmd_q == deq_pkg::CMD_POP_FRONT) begin
					head_q <= wrap_pos(deq_pkg::POS_W'(head_q) + deq_pkg::POS_W'(1));
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			cmd_q   <= deq_pkg::cmd_t'(in_cmd);
			value_q <= in_value;
		end
		if (cmd.exec) begin
			if (is_push) status_q <= full ? deq_pkg::ST_OVER : deq_pkg::ST_OK;
			else         status_q <= empty ? deq_pkg::ST_UNDER : deq_pkg::ST_OK;
		end
		if (cmd.load_out) begin
			front_q      <= empty ? '0 : rdata_a;
			back_q       <= empty ? '0 : rdata_b;
			count_q      <= occ_q;
			empty_q      <= empty;
			out_status_q <= status_q;
		end
	end

	assign front_value = front_q;
	assign back_value  = back_q;
	assign entry_count = count_q;
	assign is_empty    = empty_q;
	assign status      = out_status_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= deq_pkg::CNT_W'(deq_pkg::DEPTH))
		else $error("occupancy beyond capacity");

	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && is_push && full) |=> occ_q == $past(occ_q) && head_q == $past(head_q))
		else $error("push on full queue changed state");

	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && !is_push && empty) |=> occ_q == $past(occ_q) && head_q == $past(head_q))
		else $error("pop on empty queue changed state");

endmodule

FILE: rtl/double_ended_queue.sv
// Bounded double-ended queue of 32-bit signed values held in a ring buffer of
// deq_pkg::DEPTH entries (64). Each input transfer carries an operation in
// s_tuser (push back, push front, pop back, pop front) and a value in s_tdata
// that only pushes use. Every input transfer yields exactly one output
// transfer that reports the front and back values after the operation (zero
// when the queue is empty), the entry count, an empty flag, and a status in
// m_tuser: ok, underflow for a pop of an empty queue, or overflow for a push
// to a full queue; both faults leave the queue unchanged. An item passes
// through these steps in order: it is accepted and captured, the head and
// count move and the slot is written, the front and back slots are read
// through the registered read ports of the storage RAM, and the result
// register is loaded, which raises m_tvalid. The next item is accepted as
// soon as the result is loaded, even while that result still waits for
// m_tready; a result that cannot be loaded because the previous one is
// still waiting holds the input off until m_tready drains it. No clearing
// pass runs after reset: only slots that were written by a push ever reach
// the output.
module double_ended_queue (
	input  logic                         clk,
	input  logic                         arst_n,

	input  logic                         s_tvalid,
	output logic                         s_tready,
	// [31:0] push_value
	input  logic [deq_pkg::DATA_W-1:0]   s_tdata,
	// [1:0] cmd
	input  logic [deq_pkg::CMD_W-1:0]    s_tuser,

	output logic                         m_tvalid,
	input  logic                         m_tready,
	// [31:0] front_value, [63:32] back_value, [70:64] entry_count, [71] is_empty
	output logic [deq_pkg::OUT_W-1:0]    m_tdata,
	// [1:0] status
	output logic [deq_pkg::STAT_W-1:0]   m_tuser
);

	deq_pkg::dp_cmd_t                 dp_cmd;
	logic [deq_pkg::DATA_W-1:0]       front_value, back_value;
	logic [deq_pkg::CNT_W-1:0]        entry_count;
	logic                             is_empty;

	// The controller sequences each transfer; the datapath owns the pointers,
	// the storage and the result register.
	deq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.cmd       (dp_cmd)
	);

	deq_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (dp_cmd),
		.in_cmd      (s_tuser),
		.in_value    (s_tdata),
		.front_value (front_value),
		.back_value  (back_value),
		.entry_count (entry_count),
		.is_empty    (is_empty),
		.status      (m_tuser)
	);

	// Pack the result fields from the lowest bit up and zero the byte padding.
	assign m_tdata = deq_pkg::OUT_W'({is_empty, entry_count, back_value, front_value});

endmodule
